FILE: rtl/swrw_pkg.sv
`default_nettype none

package swrw_pkg;

  localparam int FRAME_WIDTH_DEF  = 512;
  localparam int FRAME_HEIGHT_DEF = 512;
  localparam int SINE_DEPTH       = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_DEPTH);

  localparam int COORD_W    = 9;
  localparam int COLOUR_W   = 8;
  localparam int PIX_W      = 3 * COLOUR_W;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int IMG_W_W    = 10;
  localparam int FRAC_W     = 23;
  localparam int SINE_W     = 16;
  localparam int PROD_W     = CFG_W + 1 + SINE_W;
  localparam int TOTAL_W    = PROD_W + 1;
  localparam int DISP_W     = TOTAL_W - FRAC_W - 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_X_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_END     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH = 3'd7;

  localparam logic [COORD_W-1:0] X_START_RST   = 9'd0;
  localparam logic [COORD_W-1:0] Y_START_RST   = 9'd0;
  localparam logic [COORD_W-1:0] X_END_RST     = 9'd511;
  localparam logic [COORD_W-1:0] Y_END_RST     = 9'd511;
  localparam logic [CFG_W-1:0]   AMPLITUDE_RST = 16'd1280;
  localparam logic [CFG_W-1:0]   FREQUENCY_RST = 16'd655;
  localparam logic               DIRECTION_RST = 1'b1;
  localparam int                 IMG_WIDTH_RST = 512;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic               op;
    logic               inf;
    logic               warp;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   rgb;
  } item_t;

  typedef logic [SINE_DEPTH-1:0][SINE_W-1:0] sine_rom_t;

  // Q1.15 sine, quarter-wave fold and Q2.30 Taylor series to x^13
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    longint      s;
    longint      r;
    logic        neg;
    neg = 1'b0;
    m = 64'(4 * k);
    if (m >= 64'(2 * SINE_DEPTH)) begin
      neg = 1'b1;
      m = m - 64'(2 * SINE_DEPTH);
    end
    if (m > 64'(SINE_DEPTH)) m = 64'(2 * SINE_DEPTH) - m;
    a  = (HALF_PI_Q30 * m) / SINE_DEPTH;
    a2 = (a * a) >> 30;
    t  = a;
    s  = longint'(a);
    t  = ((t * a2) >> 30) / 6;
    s  = s - longint'(t);
    t  = ((t * a2) >> 30) / 20;
    s  = s + longint'(t);
    t  = ((t * a2) >> 30) / 42;
    s  = s - longint'(t);
    t  = ((t * a2) >> 30) / 72;
    s  = s + longint'(t);
    t  = ((t * a2) >> 30) / 110;
    s  = s - longint'(t);
    t  = ((t * a2) >> 30) / 156;
    s  = s + longint'(t);
    if (s < 0) s = 0;
    r = (s + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return neg ? SINE_W'(-r) : SINE_W'(r);
  endfunction

  function automatic sine_rom_t sine_build();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_build();

endpackage

`default_nettype wire

FILE: rtl/sine_wave_region_warp_unit.sv
`default_nettype none

// Sinusoidal region warp over an RGB frame store.
// Input channel (in_valid/in_ready): opcode 0 loads one pixel into the frame
// store at (pix_x, pix_y) with row stride image_width; opcode 1 queries the
// warped pixel at (pix_x, pix_y). Only queries give a result item on the
// out_ channel (out_valid/out_ready).
// Config port: cfg_we writes cfg_wdata into register cfg_idx;
// write only while no item is in flight.
// Results leave from stage f. Throughput: one item per cycle
// when out_ready does not stall, set by the six-stage pipeline around the
// single-port frame store (one access per item, at one stage).
// Loads and queries pass the store in order, so a query sees every earlier
// load.
// Stall: each stage holds while the next is full and stalled; bubbles
// collapse, so items are still taken while a result waits for out_ready.
// Reset empties the pipeline and sets the config registers to defaults; the
// frame store keeps its contents and reads undefined until written.

module sine_wave_region_warp_unit #(
  parameter int FRAME_WIDTH  = swrw_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = swrw_pkg::FRAME_HEIGHT_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_opcode,
  input  wire  [swrw_pkg::COORD_W-1:0]       in_pix_x,
  input  wire  [swrw_pkg::COORD_W-1:0]       in_pix_y,
  input  wire  [swrw_pkg::COLOUR_W-1:0]      in_red_in,
  input  wire  [swrw_pkg::COLOUR_W-1:0]      in_green_in,
  input  wire  [swrw_pkg::COLOUR_W-1:0]      in_blue_in,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [swrw_pkg::COLOUR_W-1:0]      out_red_out,
  output logic [swrw_pkg::COLOUR_W-1:0]      out_green_out,
  output logic [swrw_pkg::COLOUR_W-1:0]      out_blue_out,
  input  wire                                cfg_we,
  input  wire  [swrw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire  [swrw_pkg::CFG_W-1:0]         cfg_wdata
);
  import swrw_pkg::*;

  localparam int MEM_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int XC_W      = $clog2(FRAME_WIDTH);
  localparam int YC_W      = $clog2(FRAME_HEIGHT);
  localparam int SW        = $clog2(FRAME_WIDTH + 1);
  localparam int HW        = $clog2(FRAME_HEIGHT + 1);
  localparam int MW0       = (SW > HW) ? SW : HW;
  localparam int MW        = (MW0 > IMG_W_W) ? MW0 : IMG_W_W;
  localparam int IDX_PW    = 16 + $clog2(SINE_DEPTH + 1);
  localparam int STRIDE_RST = (IMG_WIDTH_RST > FRAME_WIDTH) ? FRAME_WIDTH : IMG_WIDTH_RST;

  localparam logic [MW-1:0] HEIGHT_M = MW'(FRAME_HEIGHT);
  localparam logic [MW-1:0] WIDTH_M  = MW'(FRAME_WIDTH);
  localparam logic [MW-1:0] YMAX_M   = MW'(FRAME_HEIGHT - 1);

  // config registers
  logic [COORD_W-1:0] x_start_r, y_start_r, x_end_r, y_end_r;
  logic [CFG_W-1:0]   amp_r, freq_r;
  logic               dir_r;
  logic [SW-1:0]      stride_r;
  logic [MW-1:0]      width_wr;
  logic [SW-1:0]      stride_nxt;

  always_comb begin
    width_wr = MW'(cfg_wdata[IMG_W_W-1:0]);
    if (width_wr == '0) stride_nxt = SW'(1);
    else if (width_wr > WIDTH_M) stride_nxt = SW'(FRAME_WIDTH);
    else stride_nxt = SW'(width_wr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r <= X_START_RST;
      y_start_r <= Y_START_RST;
      x_end_r   <= X_END_RST;
      y_end_r   <= Y_END_RST;
      amp_r     <= AMPLITUDE_RST;
      freq_r    <= FREQUENCY_RST;
      dir_r     <= DIRECTION_RST;
      stride_r  <= SW'(STRIDE_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_X_START:   x_start_r <= cfg_wdata[COORD_W-1:0];
        REG_Y_START:   y_start_r <= cfg_wdata[COORD_W-1:0];
        REG_X_END:     x_end_r   <= cfg_wdata[COORD_W-1:0];
        REG_Y_END:     y_end_r   <= cfg_wdata[COORD_W-1:0];
        REG_AMPLITUDE: amp_r     <= cfg_wdata;
        REG_FREQUENCY: freq_r    <= cfg_wdata;
        REG_DIRECTION: dir_r     <= cfg_wdata[0];
        REG_IMG_WIDTH: stride_r  <= stride_nxt;
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  item_t a_it_r, b_it_r, c_it_r, d_it_r, e_it_r, f_it_r;
  logic [15:0]              a_phase_r;
  logic signed [SINE_W-1:0] b_sine_r;
  logic signed [PROD_W-1:0] c_prod_r;
  logic [XC_W-1:0]          d_sx_r, e_sx_r;
  logic [YC_W-1:0]          d_sy_r;
  logic [ADDR_W-1:0]        e_row_r;
  logic [PIX_W-1:0]         f_pix_r;

  logic a_free, b_free, c_free, d_free, e_free, f_free;

  assign f_free   = !f_v_r || (f_it_r.op == OP_LOAD) || out_ready;
  assign e_free   = !e_v_r || f_free;
  assign d_free   = !d_v_r || e_free;
  assign c_free   = !c_v_r || d_free;
  assign b_free   = !b_v_r || c_free;
  assign a_free   = !a_v_r || b_free;
  assign in_ready = a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      if (a_free) a_v_r <= in_valid;
      if (b_free) b_v_r <= a_v_r;
      if (c_free) c_v_r <= b_v_r;
      if (d_free) d_v_r <= c_v_r;
      if (e_free) e_v_r <= d_v_r;
      if (f_free) f_v_r <= e_v_r;
    end
  end

  // stage a: frame and rectangle tests, phase product
  logic [COORD_W-1:0] xlo, xhi, ylo, yhi, other;
  logic               in_frame, in_rect;
  logic [COORD_W+CFG_W-1:0] ph_full;
  item_t              in_it;

  always_comb begin
    xlo      = (x_start_r < x_end_r) ? x_start_r : x_end_r;
    xhi      = (x_start_r < x_end_r) ? x_end_r : x_start_r;
    ylo      = (y_start_r < y_end_r) ? y_start_r : y_end_r;
    yhi      = (y_start_r < y_end_r) ? y_end_r : y_start_r;
    in_frame = (MW'(in_pix_x) < MW'(stride_r)) && (MW'(in_pix_y) < HEIGHT_M);
    in_rect  = (in_pix_x >= xlo) && (in_pix_x <= xhi) &&
               (in_pix_y >= ylo) && (in_pix_y <= yhi);
    other    = dir_r ? in_pix_y : in_pix_x;
    ph_full  = other * freq_r;
    in_it.op   = in_opcode;
    in_it.inf  = in_frame;
    in_it.warp = (in_opcode == OP_QUERY) && in_frame && in_rect;
    in_it.x    = in_pix_x;
    in_it.y    = in_pix_y;
    in_it.rgb  = {in_red_in, in_green_in, in_blue_in};
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_it_r    <= in_it;
      a_phase_r <= ph_full[15:0];
    end
  end

  // stage b: sine lookup
  logic [IDX_PW-1:0]     idx_full;
  logic [SINE_IDX_W-1:0] sidx;

  assign idx_full = IDX_PW'(a_phase_r) * IDX_PW'(SINE_DEPTH);
  assign sidx     = idx_full[16 +: SINE_IDX_W];

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_it_r   <= a_it_r;
      b_sine_r <= SINE_ROM[sidx];
    end
  end

  // stage c: amplitude times sine
  always_ff @(posedge clk) begin
    if (c_free) begin
      c_it_r   <= b_it_r;
      c_prod_r <= $signed({1'b0, amp_r}) * b_sine_r;
    end
  end

  // stage d: displaced coordinate, clamped
  logic [COORD_W-1:0]        c_sel;
  logic signed [TOTAL_W-1:0] total;
  logic [DISP_W-1:0]         res_u;
  logic [MW-1:0]             maxc, disp;

  always_comb begin
    c_sel = dir_r ? c_it_r.x : c_it_r.y;
    total = $signed({2'b00, c_sel, {FRAC_W{1'b0}}}) + TOTAL_W'(c_prod_r);
    res_u = total[TOTAL_W-2 -: DISP_W];
    maxc  = dir_r ? (MW'(stride_r) - MW'(1)) : YMAX_M;
    if (total[TOTAL_W-1]) disp = '0;
    else if (MW'(res_u) > maxc) disp = maxc;
    else disp = MW'(res_u);
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      d_it_r <= c_it_r;
      d_sx_r <= (c_it_r.warp && dir_r)  ? XC_W'(disp) : XC_W'(c_it_r.x);
      d_sy_r <= (c_it_r.warp && !dir_r) ? YC_W'(disp) : YC_W'(c_it_r.y);
    end
  end

  // stage e: row base
  always_ff @(posedge clk) begin
    if (e_free) begin
      e_it_r  <= d_it_r;
      e_sx_r  <= d_sx_r;
      e_row_r <= ADDR_W'(d_sy_r * stride_r);
    end
  end

  // frame store access, read data held through a stall
  logic [PIX_W-1:0]  frame_mem [MEM_DEPTH];
  logic [ADDR_W-1:0] e_addr;
  logic              mem_wr, mem_rd;

  assign e_addr = e_row_r + ADDR_W'(e_sx_r);
  assign mem_wr = f_free && e_v_r && e_it_r.inf && (e_it_r.op == OP_LOAD);
  assign mem_rd = f_free && e_v_r && e_it_r.inf && (e_it_r.op == OP_QUERY);

  always_ff @(posedge clk) begin
    if (mem_wr) frame_mem[e_addr] <= e_it_r.rgb;
    if (mem_rd) f_pix_r <= frame_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (f_free) f_it_r <= e_it_r;
  end

  assign out_valid     = f_v_r && (f_it_r.op == OP_QUERY);
  assign out_red_out   = f_it_r.inf ? f_pix_r[2*COLOUR_W +: COLOUR_W] : '0;
  assign out_green_out = f_it_r.inf ? f_pix_r[COLOUR_W +: COLOUR_W] : '0;
  assign out_blue_out  = f_it_r.inf ? f_pix_r[0 +: COLOUR_W] : '0;

  a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (f_v_r && !f_free) |=> $stable(f_pix_r))
    else $error("read data changed while result stalled");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr || mem_rd) |-> ({1'b0, e_addr} < (ADDR_W + 1)'(MEM_DEPTH)))
    else $error("frame store address beyond depth");

  a_col_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (d_v_r && d_it_r.inf) |-> (MW'(d_sx_r) < MW'(stride_r)))
    else $error("source column beyond stride");

endmodule

`default_nettype wire

FILE: tb/tb_sine_wave_region_warp_unit.sv
`timescale 1ns / 100ps

module tb_sine_wave_region_warp_unit;
  import swrw_pkg::*;

  localparam int FRAME_W = 512;
  localparam int FRAME_H = 512;
  localparam int LUT_DEPTH = 1024;
  localparam int FIX_FRAC = 23;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int ITEM_GOAL = 750;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } pix_t;

  typedef struct {
    row_kind_e             kind;
    logic                  op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [PIX_W-1:0]      rgb;
    bit                    chk;
    logic [PIX_W-1:0]      want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_opcode = 1'b0;
  logic [COORD_W-1:0]   in_pix_x = '0;
  logic [COORD_W-1:0]   in_pix_y = '0;
  logic [COLOUR_W-1:0]  in_red_in = '0;
  logic [COLOUR_W-1:0]  in_green_in = '0;
  logic [COLOUR_W-1:0]  in_blue_in = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  wire                  in_ready;
  wire                  out_valid;
  wire  [COLOUR_W-1:0]  out_red_out;
  wire  [COLOUR_W-1:0]  out_green_out;
  wire  [COLOUR_W-1:0]  out_blue_out;

  // shadow of the warp registers
  logic [COORD_W-1:0] wx_start = 9'd0;
  logic [COORD_W-1:0] wy_start = 9'd0;
  logic [COORD_W-1:0] wx_end = 9'd511;
  logic [COORD_W-1:0] wy_end = 9'd511;
  logic [CFG_W-1:0]   w_amp = 16'd1280;
  logic [CFG_W-1:0]   w_freq = 16'd655;
  logic               w_dir = 1'b1;
  logic [9:0]         w_width = 10'd512;

  int               sine_lut [LUT_DEPTH];
  logic [PIX_W-1:0] pixel_store [int];
  pix_t             exp_pix_q [$];
  plan_row_t        plan [$];
  pix_t             want_pix;
  bit               calm;
  int               items_sent;
  int               bad_results;
  int               stall_left;
  int               quiet_cycles;

  sine_wave_region_warp_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_pix_x      (in_pix_x),
    .in_pix_y      (in_pix_y),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q1.15 sine by quarter-wave fold and Taylor series in Q2.30
  function automatic int q15_sine(int k);
    longint unsigned m, a, a2, t;
    longint acc, r;
    bit neg;
    int n;
    m = longint'(4 * k) % (4 * LUT_DEPTH);
    neg = 1'b0;
    if (m >= 2 * LUT_DEPTH) begin
      neg = 1'b1;
      m -= 2 * LUT_DEPTH;
    end
    if (m > LUT_DEPTH) m = 2 * LUT_DEPTH - m;
    a = QUARTER_TURN_Q30 * m / LUT_DEPTH;
    a2 = (a * a) >> 30;
    t = a;
    acc = longint'(a);
    for (n = 1; n <= 6; n++) begin
      t = ((t * a2) >> 30) / ((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    r = (acc + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return neg ? -int'(r) : int'(r);
  endfunction

  function automatic int unsigned eff_stride();
    if (w_width == 0) return 1;
    if (w_width > FRAME_W) return FRAME_W;
    return w_width;
  endfunction

  function automatic int unsigned shift_coord(int unsigned c, int unsigned other,
                                              int unsigned maxc);
    logic [15:0] phase;
    int unsigned idx;
    longint total;
    longint unsigned res;
    phase = 16'(other * w_freq);
    idx = (int'(phase) * LUT_DEPTH) >> 16;
    total = longint'(c) * (longint'(1) << FIX_FRAC) +
            longint'(w_amp) * longint'(sine_lut[idx]);
    if (total < 0) return 0;
    res = total >> FIX_FRAC;
    return (res > maxc) ? maxc : int'(res);
  endfunction

  // store address a query reads, -1 when the pixel lies off the frame
  function automatic int src_index(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned s, sx, sy, xlo, xhi, ylo, yhi;
    s = eff_stride();
    if (x >= s) return -1;
    xlo = (wx_start < wx_end) ? wx_start : wx_end;
    xhi = (wx_start < wx_end) ? wx_end : wx_start;
    ylo = (wy_start < wy_end) ? wy_start : wy_end;
    yhi = (wy_start < wy_end) ? wy_end : wy_start;
    sx = x;
    sy = y;
    if (x >= xlo && x <= xhi && y >= ylo && y <= yhi) begin
      if (w_dir) sx = shift_coord(x, y, s - 1);
      else sy = shift_coord(y, x, FRAME_H - 1);
    end
    return sy * s + sx;
  endfunction

  function automatic int pick_pause(int longest);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, longest);
  endfunction

  function automatic logic [CFG_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return CFG_W'(FRAME_W - 1);
    return $urandom_range(0, FRAME_W - 1);
  endfunction

  function automatic void item_row(logic op, int x, int y, int rgb = 0, bit chk = 0,
                                   int want = 0);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.idx = '0;
    r.val = '0;
    r.x = x;
    r.y = y;
    r.rgb = rgb;
    r.chk = chk;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t r;
    r.kind = ROW_CFG;
    r.op = OP_LOAD;
    r.idx = idx;
    r.val = val;
    r.x = '0;
    r.y = '0;
    r.rgb = '0;
    r.chk = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  task automatic drive(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                       logic [PIX_W-1:0] rgb, bit chk, logic [PIX_W-1:0] want);
    int gap;
    int a;
    int unsigned s;
    logic [PIX_W-1:0] got;
    gap = ($urandom_range(0, 2) == 0) ? pick_pause(40) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pix_x <= x;
    in_pix_y <= y;
    {in_red_in, in_green_in, in_blue_in} <= rgb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    s = eff_stride();
    if (op == OP_LOAD) begin
      if (x < s) begin
        pixel_store[y * s + x] = rgb;
        items_sent++;
      end
    end else begin
      a = src_index(x, y);
      got = (a < 0 || !pixel_store.exists(a)) ? '0 : pixel_store[a];
      exp_pix_q.push_back(pix_t'(chk ? want : got));
      items_sent++;
    end
  endtask

  // a query never reads a store entry that was not written: load it first
  task automatic query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit chk,
                       logic [PIX_W-1:0] want);
    int a;
    int unsigned s;
    a = src_index(x, y);
    s = eff_stride();
    if (a >= 0 && !pixel_store.exists(a))
      drive(OP_LOAD, COORD_W'(a % s), COORD_W'(a / s), PIX_W'($urandom), 1'b0, '0);
    drive(OP_QUERY, x, y, PIX_W'($urandom), chk, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_X_START:   wx_start = val[COORD_W-1:0];
      REG_Y_START:   wy_start = val[COORD_W-1:0];
      REG_X_END:     wx_end = val[COORD_W-1:0];
      REG_Y_END:     wy_end = val[COORD_W-1:0];
      REG_AMPLITUDE: w_amp = val;
      REG_FREQUENCY: w_freq = val;
      REG_DIRECTION: w_dir = val[0];
      REG_IMG_WIDTH: w_width = val[9:0];
      default: ;
    endcase
  endtask

  // loads leave no result, so allow for them still being in the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (exp_pix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned s;
    logic [COORD_W-1:0] x, y;
    s = eff_stride();
    if ($urandom_range(0, 9) < 6) begin
      x = $urandom_range(wx_start, wx_end);
      y = $urandom_range(wy_start, wy_end);
    end else begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end
    if (x >= s && $urandom_range(0, 9) != 0) x = x % s;
    if ($urandom_range(0, 9) < 4) drive(OP_LOAD, x, y, PIX_W'($urandom), 1'b0, '0);
    else query(x, y, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_pix_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result item r %h g %h b %h",
                     out_red_out, out_green_out, out_blue_out);
        end else begin
          want_pix = exp_pix_q.pop_front();
          if (out_red_out !== want_pix.red || out_green_out !== want_pix.green ||
              out_blue_out !== want_pix.blue) begin
            bad_results++;
            if (bad_results <= 10)
              $display("pixel mismatch: expected r %h g %h b %h, got r %h g %h b %h",
                       want_pix.red, want_pix.green, want_pix.blue,
                       out_red_out, out_green_out, out_blue_out);
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_pause(60);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sine_wave_region_warp_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i, k, base, stop;
    logic [CFG_W-1:0] v;
    for (k = 0; k < LUT_DEPTH; k++) sine_lut[k] = q15_sine(k);
    calm = 1'b0;
    items_sent = 0;
    bad_results = 0;

    // reset setup: whole frame warped, 5 px amplitude, column shift
    item_row(OP_LOAD, 0, 0, 'hFFFFFF);
    item_row(OP_QUERY, 0, 0, 0, 1, 'hFFFFFF);
    item_row(OP_LOAD, 511, 0, 'h000000);
    item_row(OP_QUERY, 511, 0, 0, 1, 'h000000);
    item_row(OP_LOAD, 511, 511, 'h5A3C96);
    item_row(OP_QUERY, 511, 511);
    item_row(OP_QUERY, 3, 128);
    // row shift, negative sine floors and clamps at the top row
    cfg_row(REG_DIRECTION, 0);
    item_row(OP_QUERY, 100, 2);
    item_row(OP_QUERY, 100, 0);
    // stride 0 acts as 1; off-frame load ignored, off-frame query gives zero
    cfg_row(REG_IMG_WIDTH, 0);
    item_row(OP_LOAD, 0, 7, 'h00FF00);
    item_row(OP_LOAD, 1, 6, 'hFF00FF);
    item_row(OP_QUERY, 0, 7, 0, 1, 'h00FF00);
    item_row(OP_QUERY, 1, 7, 0, 1, 'h000000);
    item_row(OP_QUERY, 511, 511, 0, 1, 'h000000);
    // oversized stride, reversed rectangle, full-scale amplitude and frequency
    cfg_row(REG_IMG_WIDTH, 1023);
    cfg_row(REG_X_START, 300);
    cfg_row(REG_X_END, 100);
    cfg_row(REG_Y_START, 400);
    cfg_row(REG_Y_END, 50);
    cfg_row(REG_AMPLITUDE, 'hFFFF);
    cfg_row(REG_FREQUENCY, 'hFFFF);
    cfg_row(REG_DIRECTION, 1);
    item_row(OP_QUERY, 99, 60);
    item_row(OP_QUERY, 100, 400);
    item_row(OP_QUERY, 300, 50);
    item_row(OP_QUERY, 301, 200);
    cfg_row(REG_AMPLITUDE, 0);
    cfg_row(REG_FREQUENCY, 0);
    item_row(OP_LOAD, 200, 200, 'h7F80FF);
    item_row(OP_QUERY, 200, 200, 0, 1, 'h7F80FF);
    cfg_row(REG_FREQUENCY, 16384);
    cfg_row(REG_AMPLITUDE, 256);
    cfg_row(REG_DIRECTION, 0);
    item_row(OP_QUERY, 200, 201);
    item_row(OP_QUERY, 150, 399);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) settle();
        write_reg(plan[i].idx, plan[i].val);
        if (i == plan.size() - 1 || plan[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else if (plan[i].op == OP_LOAD) begin
        drive(OP_LOAD, plan[i].x, plan[i].y, plan[i].rgb, 1'b0, '0);
      end else begin
        query(plan[i].x, plan[i].y, plan[i].chk, plan[i].want);
      end
    end

    base = items_sent;
    while (items_sent < base + ITEM_GOAL) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      write_reg(REG_X_START, pick_coord());
      write_reg(REG_Y_START, pick_coord());
      write_reg(REG_X_END, pick_coord());
      write_reg(REG_Y_END, pick_coord());
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = '1;
        2, 3: v = $urandom_range(0, 4095);
        default: v = CFG_W'($urandom);
      endcase
      write_reg(REG_AMPLITUDE, v);
      case ($urandom_range(0, 4))
        0: v = '0;
        1: v = '1;
        2: v = $urandom_range(1, 1024);
        default: v = CFG_W'($urandom);
      endcase
      write_reg(REG_FREQUENCY, v);
      write_reg(REG_DIRECTION, CFG_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = $urandom_range(1, 16);
        2: v = FRAME_W;
        3: v = $urandom_range(FRAME_W + 1, 1023);
        default: v = $urandom_range(1, FRAME_W);
      endcase
      write_reg(REG_IMG_WIDTH, v);
      cfg_we <= 1'b0;
      stop = items_sent + $urandom_range(50, 100);
      while (items_sent < stop) begin
        if ($urandom_range(0, 199) == 0) settle();
        random_item();
      end
    end

    settle();
    if (bad_results == 0) $display("tb_sine_wave_region_warp_unit OK");
    else $display("tb_sine_wave_region_warp_unit NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/swrw_pkg.sv
rtl/sine_wave_region_warp_unit.sv
tb/tb_sine_wave_region_warp_unit.sv
